@@ design/sfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Sphere frustum cull package
// Register indexes, field widths and reset values shared by the cull block.
// ----------------------------------------------------------------------------
package sfc_pkg;

    localparam int CoordW = 32;
    localparam int ParamW = 31;
    localparam int IndexW = 3;
    localparam int DepthW = 35;
    localparam int ProdW  = 63;
    localparam int SumW   = 64;
    localparam int NumSides = 4;

    localparam logic [IndexW-1:0] REG_ORTHO_MODE   = 3'd0;
    localparam logic [IndexW-1:0] REG_HALF_WIDTH   = 3'd1;
    localparam logic [IndexW-1:0] REG_HALF_HEIGHT  = 3'd2;
    localparam logic [IndexW-1:0] REG_NEAR_DEPTH   = 3'd3;
    localparam logic [IndexW-1:0] REG_FAR_DEPTH    = 3'd4;
    localparam logic [IndexW-1:0] REG_SIDE_SCALE_X = 3'd5;
    localparam logic [IndexW-1:0] REG_SIDE_SCALE_Y = 3'd6;

    localparam logic [ParamW-1:0] HALF_WIDTH_RST   = 31'd22944;
    localparam logic [ParamW-1:0] HALF_HEIGHT_RST  = 31'd22944;
    localparam logic [ParamW-1:0] NEAR_DEPTH_RST   = 31'd32768;
    localparam logic [ParamW-1:0] FAR_DEPTH_RST    = 31'd6553600;
    localparam logic [ParamW-1:0] SIDE_SCALE_X_RST = 31'd107368;
    localparam logic [ParamW-1:0] SIDE_SCALE_Y_RST = 31'd107368;

endpackage

@@ design/sphere_frustum_cull.sv @@
// ----------------------------------------------------------------------------
// Sphere frustum cull
// Decides per bounding sphere whether it may be visible in a perspective
// frustum or an orthographic box, using exact full-width fixed-point math.
// ----------------------------------------------------------------------------
// The block takes one sphere per cycle when the output side is not stalled and
// returns one visible flag per item. Stage one forms the plane cross products
// and the depth and box tests, stage two the four side distances, stage three
// the split products with the plane scale, and stage four the final compare
// with the radius into the output register. A stall at the output backs up
// through the stages without loss, and empty stages keep accepting items.
// The user must write configuration only while no item is in flight; the
// block itself does not enforce it.
module sphere_frustum_cull (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sfc_pkg::IndexW-1:0]          cfg_index,
    input  logic [sfc_pkg::ParamW-1:0]          cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [sfc_pkg::CoordW-1:0]   s_center_x,
    input  logic signed [sfc_pkg::CoordW-1:0]   s_center_y,
    input  logic signed [sfc_pkg::CoordW-1:0]   s_center_z,
    input  logic [sfc_pkg::ParamW-1:0]          s_radius,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_visible
);

    localparam int PW = sfc_pkg::ParamW;
    localparam int DW = sfc_pkg::DepthW;
    localparam int NS = sfc_pkg::NumSides;

    logic          ortho_mode_reg;
    logic [PW-1:0] half_width_reg, half_height_reg, near_depth_reg, far_depth_reg;
    logic [PW-1:0] side_scale_x_reg, side_scale_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ortho_mode_reg   <= 1'b0;
            half_width_reg   <= sfc_pkg::HALF_WIDTH_RST;
            half_height_reg  <= sfc_pkg::HALF_HEIGHT_RST;
            near_depth_reg   <= sfc_pkg::NEAR_DEPTH_RST;
            far_depth_reg    <= sfc_pkg::FAR_DEPTH_RST;
            side_scale_x_reg <= sfc_pkg::SIDE_SCALE_X_RST;
            side_scale_y_reg <= sfc_pkg::SIDE_SCALE_Y_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                sfc_pkg::REG_ORTHO_MODE:   ortho_mode_reg   <= cfg_wdata[0];
                sfc_pkg::REG_HALF_WIDTH:   half_width_reg   <= cfg_wdata;
                sfc_pkg::REG_HALF_HEIGHT:  half_height_reg  <= cfg_wdata;
                sfc_pkg::REG_NEAR_DEPTH:   near_depth_reg   <= cfg_wdata;
                sfc_pkg::REG_FAR_DEPTH:    far_depth_reg    <= cfg_wdata;
                sfc_pkg::REG_SIDE_SCALE_X: side_scale_x_reg <= cfg_wdata;
                sfc_pkg::REG_SIDE_SCALE_Y: side_scale_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline flow control.
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic adv1, adv2, adv3, adv4;

    assign adv4    = !v4_reg || m_ready;
    assign adv3    = !v3_reg || adv4;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    assign v1_next = adv1 ? s_valid : v1_reg;
    assign v2_next = adv2 ? v1_reg  : v2_reg;
    assign v3_next = adv3 ? v2_reg  : v3_reg;
    assign v4_next = adv4 ? v3_reg  : v4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    // Stage one: cross products, depth and box tests.
    logic signed [DW-1:0] cx_e, cy_e, cz_e, r_e, w_e, h_e, n_e, f_e;
    logic signed [DW-1:0] ox_lo, ox_hi, oy_lo, oy_hi, oz_lo, oz_hi, pz_near, pz_far;
    logic signed [sfc_pkg::SumW-1:0] p_wz, p_nx, p_hz, p_ny;
    logic [sfc_pkg::ProdW-1:0] p_wz_reg, p_nx_reg, p_hz_reg, p_ny_reg;
    logic [PW-1:0] r1_reg;
    logic          mode1_reg, ortho_ok1_reg, depth_ok1_reg;
    logic          ortho_ok1_next, depth_ok1_next;

    always_comb begin
        cx_e = {{(DW-sfc_pkg::CoordW){s_center_x[sfc_pkg::CoordW-1]}}, s_center_x};
        cy_e = {{(DW-sfc_pkg::CoordW){s_center_y[sfc_pkg::CoordW-1]}}, s_center_y};
        cz_e = {{(DW-sfc_pkg::CoordW){s_center_z[sfc_pkg::CoordW-1]}}, s_center_z};
        r_e  = {{(DW-PW){1'b0}}, s_radius};
        w_e  = {{(DW-PW){1'b0}}, half_width_reg};
        h_e  = {{(DW-PW){1'b0}}, half_height_reg};
        n_e  = {{(DW-PW){1'b0}}, near_depth_reg};
        f_e  = {{(DW-PW){1'b0}}, far_depth_reg};

        ox_lo   = cx_e + r_e + w_e;
        ox_hi   = cx_e - r_e - w_e;
        oy_lo   = cy_e + r_e + h_e;
        oy_hi   = cy_e - r_e - h_e;
        oz_lo   = cz_e + r_e - n_e;
        oz_hi   = cz_e - r_e - f_e;
        pz_near = r_e - cz_e - n_e;
        pz_far  = -cz_e - r_e - f_e;

        ortho_ok1_next = (!ox_lo[DW-1] && ox_lo != '0) && ox_hi[DW-1] &&
                         (!oy_lo[DW-1] && oy_lo != '0) && oy_hi[DW-1] &&
                         (!oz_lo[DW-1] && oz_lo != '0) && oz_hi[DW-1];
        depth_ok1_next = !pz_near[DW-1] && (pz_far[DW-1] || pz_far == '0);

        p_wz = $signed({1'b0, half_width_reg})  * s_center_z;
        p_nx = $signed({1'b0, near_depth_reg})  * s_center_x;
        p_hz = $signed({1'b0, half_height_reg}) * s_center_z;
        p_ny = $signed({1'b0, near_depth_reg})  * s_center_y;
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            p_wz_reg      <= p_wz[sfc_pkg::ProdW-1:0];
            p_nx_reg      <= p_nx[sfc_pkg::ProdW-1:0];
            p_hz_reg      <= p_hz[sfc_pkg::ProdW-1:0];
            p_ny_reg      <= p_ny[sfc_pkg::ProdW-1:0];
            r1_reg        <= s_radius;
            mode1_reg     <= ortho_mode_reg;
            ortho_ok1_reg <= ortho_ok1_next;
            depth_ok1_reg <= depth_ok1_next;
        end
    end

    // Stage two: signed distances to the left, right, bottom and top planes.
    logic [sfc_pkg::SumW-1:0] side2_next [NS];
    logic [sfc_pkg::SumW-1:0] side2_reg  [NS];
    logic [sfc_pkg::SumW-1:0] wz_e, nx_e, hz_e, ny_e;
    logic [PW-1:0] r2_reg;
    logic          mode2_reg, ortho_ok2_reg, depth_ok2_reg;

    always_comb begin
        wz_e = {p_wz_reg[sfc_pkg::ProdW-1], p_wz_reg};
        nx_e = {p_nx_reg[sfc_pkg::ProdW-1], p_nx_reg};
        hz_e = {p_hz_reg[sfc_pkg::ProdW-1], p_hz_reg};
        ny_e = {p_ny_reg[sfc_pkg::ProdW-1], p_ny_reg};
        side2_next[0] = wz_e - nx_e;
        side2_next[1] = wz_e + nx_e;
        side2_next[2] = hz_e - ny_e;
        side2_next[3] = hz_e + ny_e;
    end

    always_ff @(posedge aclk) begin
        if (adv2) begin
            side2_reg     <= side2_next;
            r2_reg        <= r1_reg;
            mode2_reg     <= mode1_reg;
            ortho_ok2_reg <= ortho_ok1_reg;
            depth_ok2_reg <= depth_ok1_reg;
        end
    end

    // Stage three: split products of each distance with its scale, and a flag for each positive distance.
    logic [62:0] lo3_next [NS];
    logic [61:0] hi3_next [NS];
    logic [62:0] lo3_reg  [NS];
    logic [61:0] hi3_reg  [NS];
    logic [NS-1:0] pos3_next, pos3_reg;
    logic [PW-1:0] scale3 [NS];
    logic [PW-1:0] r3_reg;
    logic          mode3_reg, ortho_ok3_reg, depth_ok3_reg;

    always_comb begin
        for (int i = 0; i < NS; i++) begin
            scale3[i]    = (i < 2) ? side_scale_x_reg : side_scale_y_reg;
            pos3_next[i] = !side2_reg[i][63] && (side2_reg[i][62:0] != '0);
            lo3_next[i]  = side2_reg[i][31:0] * scale3[i];
            hi3_next[i]  = side2_reg[i][62:32] * scale3[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv3) begin
            lo3_reg       <= lo3_next;
            hi3_reg       <= hi3_next;
            pos3_reg      <= pos3_next;
            r3_reg        <= r2_reg;
            mode3_reg     <= mode2_reg;
            ortho_ok3_reg <= ortho_ok2_reg;
            depth_ok3_reg <= depth_ok2_reg;
        end
    end

    // Stage four: compare each scaled distance with the radius and select the result for the mode.
    logic [62:0]   hiword4 [NS];
    logic [NS-1:0] cull4;
    logic          visible_next, visible_reg;

    always_comb begin
        for (int i = 0; i < NS; i++) begin
            hiword4[i] = {1'b0, hi3_reg[i]} + {32'd0, lo3_reg[i][62:32]};
            cull4[i]   = pos3_reg[i] &&
                         ((hiword4[i] > {32'd0, r3_reg}) ||
                          (hiword4[i] == {32'd0, r3_reg} && lo3_reg[i][31:0] != '0));
        end
        visible_next = mode3_reg ? ortho_ok3_reg : (depth_ok3_reg && (cull4 == '0));
    end

    always_ff @(posedge aclk) begin
        if (adv4) begin
            visible_reg <= visible_next;
        end
    end

    assign m_valid   = v4_reg;
    assign m_visible = visible_reg;

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && !m_ready))
        else $error("input blocked while the pipeline has a free stage");

    a_no_invented_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (!v3_reg && m_ready) |=> !m_valid)
        else $error("result appeared without an item behind it");

    a_ortho_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && adv4 && mode3_reg) |=> (m_visible == $past(ortho_ok3_reg)))
        else $error("orthographic result differs from the box test");

    a_depth_cull: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && adv4 && !mode3_reg && !depth_ok3_reg) |=> !m_visible)
        else $error("sphere outside the depth range was not culled");

endmodule
